// File: design/preset_countdown_timer_defines.svh
// assertion macros for the preset countdown timer
`ifndef PRESET_COUNTDOWN_TIMER_DEFINES_SVH
`define PRESET_COUNTDOWN_TIMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PCT_ASSERT_CLK(name, ck, rn, prop, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`define PCT_ASSERT(name, prop, msg) \
    `PCT_ASSERT_CLK(name, clk, rst_n, prop, msg)

`else

`define PCT_ASSERT_CLK(name, ck, rn, prop, msg)

`define PCT_ASSERT(name, prop, msg)

`endif

`endif

// File: design/ptmr_pkg.sv
package ptmr_pkg;

    localparam int PRESET_NUM = 6;
    localparam int PRESET_W   = 16;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int MIN_W      = 11;
    localparam int SEC_W      = 6;

    localparam int PRESET_COUNT_DEF     = 6;
    localparam int TICKS_PER_SECOND_DEF = 1000;

    typedef logic [PRESET_NUM-1:0][PRESET_W-1:0] preset_arr_t;

    localparam preset_arr_t PRESET_RESET = {
        16'd7200, 16'd3600, 16'd1800, 16'd900, 16'd300, 16'd60
    };

    localparam logic [SLOT_W-1:0]   RESET_SLOT    = 3'd2;
    localparam logic [PRESET_W-1:0] RESET_SECONDS = 16'd900;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    localparam logic [1:0] BTN_MENU  = 2'd0;
    localparam logic [1:0] BTN_PLUS  = 2'd1;
    localparam logic [1:0] BTN_MINUS = 2'd2;

    localparam logic [1:0] RUN_IDLE     = 2'd0;
    localparam logic [1:0] RUN_RUNNING  = 2'd1;
    localparam logic [1:0] RUN_PAUSED   = 2'd2;
    localparam logic [1:0] RUN_FINISHED = 2'd3;

    // x / 60 = (x >> 2) / 15, and / 15 is a multiply by ceil(2^19 / 15)
    localparam int          DIV_IN_W  = PRESET_W - 2;
    localparam int          DIV_SHIFT = 19;
    localparam int          DIV_MUL_W = 16;
    localparam logic [15:0] DIV15_MUL = 16'd34953;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_RUNNING  = 4'b0010,
        MODE_PAUSED   = 4'b0100,
        MODE_FINISHED = 4'b1000
    } mode_t;

    typedef struct packed {
        logic                handled;
        logic [1:0]          run_state;
        logic [PRESET_W-1:0] seconds;
        logic [SLOT_W-1:0]   slot;
        logic                done;
    } res_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            MODE_IDLE:     c = RUN_IDLE;
            MODE_RUNNING:  c = RUN_RUNNING;
            MODE_PAUSED:   c = RUN_PAUSED;
            MODE_FINISHED: c = RUN_FINISHED;
            default:       c = RUN_IDLE;
        endcase
        return c;
    endfunction

endpackage

// File: design/ptmr_cfg.sv
module ptmr_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptmr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptmr_pkg::PRESET_W-1:0]     cfg_data,
    output ptmr_pkg::preset_arr_t             presets
);

    ptmr_pkg::preset_arr_t presets_reg;
    ptmr_pkg::preset_arr_t presets_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        presets_next = presets_reg;
        for (int i = 0; i < ptmr_pkg::PRESET_NUM; i++)
        begin
            if (cfg_valid && cfg_ready && cfg_index == ptmr_pkg::CFG_IDX_W'(i))
            begin
                presets_next[i] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presets_reg <= ptmr_pkg::PRESET_RESET;
        end
        else
        begin
            presets_reg <= presets_next;
        end
    end

    assign presets = presets_reg;

endmodule

// File: design/ptmr_core.sv
`include "preset_countdown_timer_defines.svh"

module ptmr_core #(
    parameter int PRESET_COUNT     = ptmr_pkg::PRESET_COUNT_DEF,
    parameter int TICKS_PER_SECOND = ptmr_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         item_func,
    input  logic [1:0]                   item_btn,
    input  logic                         item_short,
    input  ptmr_pkg::preset_arr_t        presets,
    output ptmr_pkg::res_t               res
);

    localparam int PH_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int SW   = ptmr_pkg::SLOT_W;
    localparam int PW   = ptmr_pkg::PRESET_W;

    ptmr_pkg::mode_t mode_reg, mode_next;
    logic [PW-1:0]   sec_reg, sec_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic            mark_reg, mark_next;
    logic            handled;
    ptmr_pkg::res_t  res_reg;

    logic [PH_W-1:0] phase_inc;
    logic [PW-1:0]   sec_dec;
    logic [SW-1:0]   slot_adv;
    logic [PW-1:0]   preset_cur;
    logic [PW-1:0]   preset_adv;

    function automatic logic [PW-1:0] pick(input ptmr_pkg::preset_arr_t p,
                                           input logic [SW-1:0] s);
        logic [PW-1:0] v;
        v = '0;
        for (int i = 0; i < ptmr_pkg::PRESET_NUM; i++)
        begin
            if (s == SW'(i))
            begin
                v = p[i];
            end
        end
        return v;
    endfunction

    assign phase_inc  = phase_reg + PH_W'(1);
    assign sec_dec    = (sec_reg != '0) ? sec_reg - PW'(1) : sec_reg;
    assign slot_adv   = (slot_reg == SW'(PRESET_COUNT - 1)) ? '0 : slot_reg + SW'(1);
    assign preset_cur = pick(presets, slot_reg);
    assign preset_adv = pick(presets, slot_adv);

    always_comb
    begin
        mode_next  = mode_reg;
        sec_next   = sec_reg;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        mark_next  = mark_reg;
        handled    = 1'b0;
        if (item_func == ptmr_pkg::FUNC_TICK)
        begin
            if (mode_reg == ptmr_pkg::MODE_RUNNING)
            begin
                if (phase_inc == PH_W'(TICKS_PER_SECOND))
                begin
                    phase_next = '0;
                    sec_next   = sec_dec;
                    if (sec_dec == '0)
                    begin
                        mode_next = ptmr_pkg::MODE_FINISHED;
                        mark_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = phase_inc;
                end
            end
        end
        else if (item_short)
        begin
            if (mode_reg == ptmr_pkg::MODE_FINISHED)
            begin
                handled    = 1'b1;
                mode_next  = ptmr_pkg::MODE_IDLE;
                sec_next   = preset_cur;
                phase_next = '0;
                mark_next  = 1'b0;
            end
            else
            begin
                case (item_btn)
                    ptmr_pkg::BTN_MENU:
                    begin
                        handled = 1'b1;
                        if (mode_reg == ptmr_pkg::MODE_IDLE)
                        begin
                            slot_next = slot_adv;
                            sec_next  = preset_adv;
                        end
                        else
                        begin
                            mode_next  = ptmr_pkg::MODE_IDLE;
                            sec_next   = preset_cur;
                            phase_next = '0;
                            mark_next  = 1'b0;
                        end
                    end
                    ptmr_pkg::BTN_PLUS:
                    begin
                        handled = 1'b1;
                        if (mode_reg inside {ptmr_pkg::MODE_IDLE, ptmr_pkg::MODE_PAUSED})
                        begin
                            mode_next  = ptmr_pkg::MODE_RUNNING;
                            phase_next = '0;
                        end
                    end
                    ptmr_pkg::BTN_MINUS:
                    begin
                        handled = 1'b1;
                        if (mode_reg == ptmr_pkg::MODE_RUNNING)
                        begin
                            mode_next = ptmr_pkg::MODE_PAUSED;
                        end
                        else
                        begin
                            mode_next  = ptmr_pkg::MODE_IDLE;
                            sec_next   = preset_cur;
                            phase_next = '0;
                            mark_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        handled = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ptmr_pkg::MODE_IDLE;
            sec_reg   <= ptmr_pkg::RESET_SECONDS;
            phase_reg <= '0;
            slot_reg  <= ptmr_pkg::RESET_SLOT;
            mark_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            sec_reg   <= sec_next;
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg.handled   <= handled;
            res_reg.run_state <= ptmr_pkg::mode_code(mode_next);
            res_reg.seconds   <= sec_next;
            res_reg.slot      <= slot_next;
            res_reg.done      <= mark_next;
        end
    end

    assign res = res_reg;

    `PCT_ASSERT(a_mark_matches_finished,
        mark_reg == (mode_reg == ptmr_pkg::MODE_FINISHED),
        "done mark out of step with finished mode")
    `PCT_ASSERT(a_phase_in_range, phase_reg < PH_W'(TICKS_PER_SECOND),
        "tick phase out of range")
    `PCT_ASSERT(a_slot_in_range, slot_reg < SW'(PRESET_COUNT), "preset slot out of range")
    `PCT_ASSERT(a_idle_phase_clear,
        step && mode_next == ptmr_pkg::MODE_IDLE && mode_reg != ptmr_pkg::MODE_IDLE
            |=> phase_reg == '0,
        "phase not cleared on timer reset")

endmodule

// File: design/ptmr_disp.sv
module ptmr_disp (
    input  logic                             clk,
    input  logic                             load,
    input  ptmr_pkg::res_t                   res,
    output logic                             key_handled,
    output logic [1:0]                       run_state,
    output logic [ptmr_pkg::PRESET_W-1:0]    remaining_seconds,
    output logic [ptmr_pkg::MIN_W-1:0]       shown_minutes,
    output logic [ptmr_pkg::SEC_W-1:0]       shown_seconds,
    output logic [ptmr_pkg::SLOT_W-1:0]      selected_preset,
    output logic                             done_flag
);

    localparam int PW     = ptmr_pkg::PRESET_W;
    localparam int NW     = ptmr_pkg::DIV_IN_W;
    localparam int PROD_W = NW + ptmr_pkg::DIV_MUL_W;
    localparam int QW     = ptmr_pkg::MIN_W;
    localparam int RW     = PW + 1;

    logic [NW-1:0]     quarter;
    logic [PROD_W-1:0] prod;
    logic [QW-1:0]     quot;
    logic [RW-1:0]     q_times60;
    logic [RW-1:0]     rem;

    logic              handled_reg;
    logic [1:0]        run_reg;
    logic [PW-1:0]     sec_reg;
    logic [QW-1:0]     min_reg;
    logic [ptmr_pkg::SEC_W-1:0]  sec60_reg;
    logic [ptmr_pkg::SLOT_W-1:0] slot_reg;
    logic              done_reg;

    assign quarter   = res.seconds[PW-1:2];
    assign prod      = PROD_W'(quarter) * PROD_W'(ptmr_pkg::DIV15_MUL);
    assign quot      = prod[ptmr_pkg::DIV_SHIFT +: QW];
    assign q_times60 = (RW'(quot) << 6) - (RW'(quot) << 2);
    assign rem       = RW'(res.seconds) - q_times60;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            handled_reg <= res.handled;
            run_reg     <= res.run_state;
            sec_reg     <= res.seconds;
            min_reg     <= quot;
            sec60_reg   <= rem[ptmr_pkg::SEC_W-1:0];
            slot_reg    <= res.slot;
            done_reg    <= res.done;
        end
    end

    assign key_handled       = handled_reg;
    assign run_state         = run_reg;
    assign remaining_seconds = sec_reg;
    assign shown_minutes     = min_reg;
    assign shown_seconds     = sec60_reg;
    assign selected_preset   = slot_reg;
    assign done_flag         = done_reg;

endmodule

// File: design/preset_countdown_timer.sv
// Countdown timer with selectable presets. Every item (a one millisecond tick or a key event)
// gives exactly one result that reports the timer after that item. The block takes one item
// per clock while no stall holds it back, and each accepted item passes an input register, the
// state update register and the display register, where remaining seconds are split into
// minutes and seconds by a constant multiply. A stall on the output reaches back through the
// ready chain combinationally, so items keep flowing as long as a stage ahead has room. The
// preset durations are written through the configuration port, which is always ready; write
// them only while no item is in flight. A write takes effect at the next reload of the count.
`include "preset_countdown_timer_defines.svh"

module preset_countdown_timer #(
    parameter int PRESET_COUNT     = ptmr_pkg::PRESET_COUNT_DEF,
    parameter int TICKS_PER_SECOND = ptmr_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [1:0]                       key_button,
    input  logic                             short_press,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             key_handled,
    output logic [1:0]                       run_state,
    output logic [ptmr_pkg::PRESET_W-1:0]    remaining_seconds,
    output logic [ptmr_pkg::MIN_W-1:0]       shown_minutes,
    output logic [ptmr_pkg::SEC_W-1:0]       shown_seconds,
    output logic [ptmr_pkg::SLOT_W-1:0]      selected_preset,
    output logic                             done_flag,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptmr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptmr_pkg::PRESET_W-1:0]    cfg_data
);

    logic       s1_valid_reg, s1_valid_next;
    logic       s2_valid_reg, s2_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       func_reg;
    logic [1:0] btn_reg;
    logic       short_reg;

    logic       s3_ready;
    logic       s2_ready;
    logic       s1_ready;
    logic       in_take;
    logic       step;
    logic       load;

    ptmr_pkg::preset_arr_t presets;
    ptmr_pkg::res_t        res;

    assign s3_ready = !out_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign in_take  = in_valid && s1_ready;
    assign step     = s1_valid_reg && s2_ready;
    assign load     = s2_valid_reg && s3_ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s2_ready);
    assign s2_valid_next  = step || (s2_valid_reg && !s3_ready);
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg  <= func;
            btn_reg   <= key_button;
            short_reg <= short_press;
        end
    end

    assign out_valid = out_valid_reg;

    ptmr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .presets   (presets)
    );

    ptmr_core #(
        .PRESET_COUNT     (PRESET_COUNT),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item_func  (func_reg),
        .item_btn   (btn_reg),
        .item_short (short_reg),
        .presets    (presets),
        .res        (res)
    );

    ptmr_disp u_disp (
        .clk               (clk),
        .load              (load),
        .res               (res),
        .key_handled       (key_handled),
        .run_state         (run_state),
        .remaining_seconds (remaining_seconds),
        .shown_minutes     (shown_minutes),
        .shown_seconds     (shown_seconds),
        .selected_preset   (selected_preset),
        .done_flag         (done_flag)
    );

    `PCT_ASSERT(a_s2_holds_on_stall,
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(res),
        "state result lost while stalled")

endmodule
